// ----- rtl/rdpm_pkg.sv -----
// shared types and constants for the radial distortion pixel map
`timescale 1ns / 1ps
`default_nettype none
package rdpm_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FH    = 3'd4;

    localparam logic [7:0]  LEVEL_RST = 8'd65;
    localparam logic [12:0] FRAME_RST = 13'd400;

    localparam logic signed [9:0]  LEVEL_ZERO = 10'sd65;
    localparam logic signed [27:0] K_SCALE4   = 28'sd40000000;

    localparam int DEST_W = 12;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       okx;
        logic       oky;
    } t_side;

endpackage
`default_nettype wire

// ----- rtl/radial_distortion_pixel_map_top.sv -----
// top level of the radial distortion pixel map
//
// input channel: i_valid / o_stall carry one source pixel per beat (column,
// row, colour). output channel: o_valid / i_stall carry one mapped pixel per
// beat: target column and row, the colour unchanged and o_dest_valid, which is
// high only when the target lies inside the frame and the denominator is
// positive; an invalid target reads as column and row zero.
// throughput: one beat per cycle while the output is not stalled. the
// pipeline holds six front stages, one division cell per quotient bit and
// the output register.
// when the receiver stalls a held output beat, the whole pipeline freezes and
// o_stall rises in the same cycle; nothing is dropped.
// configuration: i_cfg_we, i_cfg_idx, i_cfg_data write one register per
// cycle; user must write only while the pipeline is empty (not enforced).
// reset (synchronous, active low) empties the pipeline and restores the
// registers to level 65, offsets 0 and a 400 by 400 frame.
`timescale 1ns / 1ps
`default_nettype none
module radial_distortion_pixel_map_top #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [11:0]                   i_src_col,
    input  wire logic [11:0]                   i_src_row,
    input  wire logic [7:0]                    i_red_in,
    input  wire logic [7:0]                    i_green_in,
    input  wire logic [7:0]                    i_blue_in,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [11:0]                        o_dest_col,
    output logic [11:0]                        o_dest_row,
    output logic [7:0]                         o_red_out,
    output logic [7:0]                         o_green_out,
    output logic [7:0]                         o_blue_out,
    output logic                               o_dest_valid,
    input  wire logic                          i_cfg_we,
    input  wire logic [rdpm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rdpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rdpm_pkg::*;

    localparam int NW  = $clog2(MAX_DIM + 1);
    localparam int NE  = NW + 1;
    localparam int QB  = $clog2(MAX_DIM);
    localparam int AW  = ((NW > 13) ? NW : 13) + 1;
    localparam int SW  = 2 * (AW + 1) - 1;
    localparam int PW  = SW + 10;
    localparam int DW  = ((PW > 27) ? PW : 27) + 1;
    localparam int XW  = DW + QB;

    logic               en;
    logic [7:0]         r_level;
    logic signed [11:0] r_cx, r_cy;
    logic [12:0]        r_fw, r_fh;
    logic [NW-1:0]      nw, nh;
    t_side              in_side;

    logic               c_vld  [QB+1];
    t_side              c_side [QB+1];
    logic [DW-1:0]      c_d2   [QB+1];
    logic [XW-1:0]      c_rx   [QB+1];
    logic [XW-1:0]      c_ry   [QB+1];
    logic [QB-1:0]      c_qx   [QB+1];
    logic [QB-1:0]      c_qy   [QB+1];

    logic [NE-1:0]      qxe, qye, nxm, nym;
    logic               vx, vy, vxy;
    logic               r_ovld;
    logic [11:0]        r_col, r_row;
    logic [7:0]         r_red, r_green, r_blue;
    logic               r_dvld;

    assign en      = !(r_ovld && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RST;
            r_cx    <= '0;
            r_cy    <= '0;
            r_fw    <= FRAME_RST;
            r_fh    <= FRAME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEVEL: r_level <= i_cfg_data[7:0];
                CFG_CX:    r_cx    <= signed'(i_cfg_data[11:0]);
                CFG_CY:    r_cy    <= signed'(i_cfg_data[11:0]);
                CFG_FW:    r_fw    <= i_cfg_data;
                CFG_FH:    r_fh    <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    assign nw = (r_fw > MAX_DIM) ? NW'(MAX_DIM) : NW'(r_fw);
    assign nh = (r_fh > MAX_DIM) ? NW'(MAX_DIM) : NW'(r_fh);

    always_comb begin
        in_side       = '0;
        in_side.red   = i_red_in;
        in_side.green = i_green_in;
        in_side.blue  = i_blue_in;
    end

    rdpm_front #(
        .NW      (NW),
        .DW      (DW),
        .XW      (XW),
        .QB      (QB)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid && en),
        .i_col   (i_src_col),
        .i_row   (i_src_row),
        .i_side  (in_side),
        .i_level (r_level),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_nw    (nw),
        .i_nh    (nh),
        .o_vld   (c_vld[0]),
        .o_side  (c_side[0]),
        .o_d2    (c_d2[0]),
        .o_rx    (c_rx[0]),
        .o_ry    (c_ry[0])
    );

    assign c_qx[0] = '0;
    assign c_qy[0] = '0;

    for (genvar j = 0; j < QB; j++) begin : g_cell
        rdpm_cell #(
            .DW    (DW),
            .XW    (XW),
            .QB    (QB),
            .SHIFT (QB - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (c_vld[j]),
            .i_side  (c_side[j]),
            .i_d2    (c_d2[j]),
            .i_rx    (c_rx[j]),
            .i_ry    (c_ry[j]),
            .i_qx    (c_qx[j]),
            .i_qy    (c_qy[j]),
            .o_vld   (c_vld[j+1]),
            .o_side  (c_side[j+1]),
            .o_d2    (c_d2[j+1]),
            .o_rx    (c_rx[j+1]),
            .o_ry    (c_ry[j+1]),
            .o_qx    (c_qx[j+1]),
            .o_qy    (c_qy[j+1])
        );
    end

    // target must satisfy num <= (n-1) * 2d exactly
    assign qxe = NE'(c_qx[QB]);
    assign qye = NE'(c_qy[QB]);
    assign nxm = NE'(nw) - NE'(1);
    assign nym = NE'(nh) - NE'(1);
    assign vx  = c_side[QB].okx && (nw != '0)
                 && ((qxe < nxm) || ((qxe == nxm) && (c_rx[QB] == '0)));
    assign vy  = c_side[QB].oky && (nh != '0)
                 && ((qye < nym) || ((qye == nym) && (c_ry[QB] == '0)));
    assign vxy = vx && vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= c_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col   <= vxy ? DEST_W'(c_qx[QB]) : '0;
            r_row   <= vxy ? DEST_W'(c_qy[QB]) : '0;
            r_dvld  <= vxy;
            r_red   <= c_side[QB].red;
            r_green <= c_side[QB].green;
            r_blue  <= c_side[QB].blue;
        end
    end

    assign o_valid      = r_ovld;
    assign o_dest_col   = r_col;
    assign o_dest_row   = r_row;
    assign o_red_out    = r_red;
    assign o_green_out  = r_green;
    assign o_blue_out   = r_blue;
    assign o_dest_valid = r_dvld;

endmodule
`default_nettype wire

// ----- rtl/rdpm_front.sv -----
// front pipeline: centred offsets, squared radius, denominator and numerators
`timescale 1ns / 1ps
`default_nettype none
module rdpm_front #(
    parameter int NW = 13,
    parameter int DW = 40,
    parameter int XW = 52,
    parameter int QB = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire logic [11:0]          i_col,
    input  wire logic [11:0]          i_row,
    input  wire rdpm_pkg::t_side      i_side,
    input  wire logic [7:0]           i_level,
    input  wire logic signed [11:0]   i_cx,
    input  wire logic signed [11:0]   i_cy,
    input  wire logic [NW-1:0]        i_nw,
    input  wire logic [NW-1:0]        i_nh,
    output logic                      o_vld,
    output rdpm_pkg::t_side           o_side,
    output logic [DW-1:0]             o_d2,
    output logic [XW-1:0]             o_rx,
    output logic [XW-1:0]             o_ry
);
    import rdpm_pkg::*;

    localparam int AW   = ((NW > 13) ? NW : 13) + 1;
    localparam int DXW  = AW + 1;
    localparam int SW   = 2 * DXW - 1;
    localparam int PW   = SW + 10;
    localparam int NUMW = (((AW + 28) > (NW + 1 + DW)) ? (AW + 28) : (NW + 1 + DW)) + 1;
    localparam int YW   = (NUMW > XW) ? NUMW : XW;

    logic signed [AW-1:0]  ax, ay, wn, hn;
    logic signed [DXW-1:0] cx2, cy2;
    logic signed [AW-1:0]  r0_ax, r0_ay, r1_ax, r1_ay, r2_ax, r2_ay, r3_ax, r3_ay;
    logic signed [DXW-1:0] r0_dx, r0_dy;
    logic signed [2*DXW-1:0] sqx, sqy;
    logic [SW-1:0]         r1_s;
    logic signed [9:0]     lvl;
    logic signed [PW-1:0]  pr;
    logic signed [PW-1:0]  r2_p;
    logic signed [DW-1:0]  dd, r3_d;
    logic                  r3_dpos, r4_dpos;
    logic signed [AW+27:0] kx, ky;
    logic signed [NW+DW:0] wx, hy;
    logic signed [NUMW-1:0] r4_nx, r4_ny;
    logic [DW-1:0]         r4_d2;
    logic [YW-1:0]         lim;
    t_side                 r0_side, r1_side, r2_side, r3_side, r4_side, r5_side;
    logic [5:0]            r_vld;
    logic [XW-1:0]         r5_rx, r5_ry;
    logic [DW-1:0]         r5_d2;

    assign wn  = signed'(AW'(i_nw));
    assign hn  = signed'(AW'(i_nh));
    assign ax  = signed'(AW'({i_col, 1'b0})) - wn;
    assign ay  = signed'(AW'({i_row, 1'b0})) - hn;
    assign cx2 = DXW'(signed'({i_cx, 1'b0}));
    assign cy2 = DXW'(signed'({i_cy, 1'b0}));

    assign sqx = r0_dx * r0_dx;
    assign sqy = r0_dy * r0_dy;
    assign lvl = signed'({2'b00, i_level}) - LEVEL_ZERO;
    assign pr  = lvl * signed'({1'b0, r1_s});
    assign dd  = DW'(r2_p) + DW'(K_SCALE4);
    assign kx  = r3_ax * K_SCALE4;
    assign ky  = r3_ay * K_SCALE4;
    assign wx  = signed'({1'b0, i_nw}) * r3_d;
    assign hy  = signed'({1'b0, i_nh}) * r3_d;
    assign lim = YW'(r4_d2) << QB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 0: centred coordinates
            r0_ax   <= ax;
            r0_ay   <= ay;
            r0_dx   <= DXW'(ax) - cx2;
            r0_dy   <= DXW'(ay) - cy2;
            r0_side <= i_side;
            // stage 1: squared radius
            r1_s    <= SW'(sqx) + SW'(sqy);
            r1_ax   <= r0_ax;
            r1_ay   <= r0_ay;
            r1_side <= r0_side;
            // stage 2: coefficient product
            r2_p    <= pr;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_side <= r1_side;
            // stage 3: denominator
            r3_d    <= dd;
            r3_dpos <= !dd[DW-1] && (dd != '0);
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_side <= r2_side;
            // stage 4: numerators
            r4_nx   <= NUMW'(kx) + NUMW'(wx);
            r4_ny   <= NUMW'(ky) + NUMW'(hy);
            r4_d2   <= DW'(unsigned'(r3_d)) << 1;
            r4_dpos <= r3_dpos;
            r4_side <= r3_side;
            // stage 5: sign and range precheck
            r5_rx   <= XW'(unsigned'(r4_nx));
            r5_ry   <= XW'(unsigned'(r4_ny));
            r5_d2   <= r4_d2;
            r5_side.red   <= r4_side.red;
            r5_side.green <= r4_side.green;
            r5_side.blue  <= r4_side.blue;
            r5_side.okx <= r4_dpos && !r4_nx[NUMW-1] && (YW'(unsigned'(r4_nx)) < lim);
            r5_side.oky <= r4_dpos && !r4_ny[NUMW-1] && (YW'(unsigned'(r4_ny)) < lim);
        end
    end

    assign o_vld  = r_vld[5];
    assign o_side = r5_side;
    assign o_d2   = r5_d2;
    assign o_rx   = r5_rx;
    assign o_ry   = r5_ry;

endmodule
`default_nettype wire

// ----- rtl/rdpm_cell.sv -----
// one restoring division cell: one quotient bit for both axes
`timescale 1ns / 1ps
`default_nettype none
module rdpm_cell #(
    parameter int DW = 40,
    parameter int XW = 52,
    parameter int QB = 12,
    parameter int SHIFT = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire rdpm_pkg::t_side i_side,
    input  wire logic [DW-1:0]   i_d2,
    input  wire logic [XW-1:0]   i_rx,
    input  wire logic [XW-1:0]   i_ry,
    input  wire logic [QB-1:0]   i_qx,
    input  wire logic [QB-1:0]   i_qy,
    output logic                 o_vld,
    output rdpm_pkg::t_side      o_side,
    output logic [DW-1:0]        o_d2,
    output logic [XW-1:0]        o_rx,
    output logic [XW-1:0]        o_ry,
    output logic [QB-1:0]        o_qx,
    output logic [QB-1:0]        o_qy
);
    import rdpm_pkg::*;

    logic [XW-1:0] dsh;
    logic [XW:0]   tx, ty;
    logic [QB-1:0] bitm;
    logic          r_vld;
    t_side         r_side;
    logic [DW-1:0] r_d2;
    logic [XW-1:0] r_rx, r_ry;
    logic [QB-1:0] r_qx, r_qy;

    assign dsh  = XW'(i_d2) << SHIFT;
    assign tx   = {1'b0, i_rx} - {1'b0, dsh};
    assign ty   = {1'b0, i_ry} - {1'b0, dsh};
    assign bitm = QB'(1) << SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_d2   <= i_d2;
            r_rx   <= tx[XW] ? i_rx : tx[XW-1:0];
            r_ry   <= ty[XW] ? i_ry : ty[XW-1:0];
            r_qx   <= tx[XW] ? i_qx : (i_qx | bitm);
            r_qy   <= ty[XW] ? i_qy : (i_qy | bitm);
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_d2   = r_d2;
    assign o_rx   = r_rx;
    assign o_ry   = r_ry;
    assign o_qx   = r_qx;
    assign o_qy   = r_qy;

endmodule
`default_nettype wire

// ----- rtl/rdpm_check.sv -----
// port-level checks for the radial distortion pixel map, bound to the top
`timescale 1ns / 1ps
`default_nettype none
module rdpm_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_stall,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic [11:0] o_dest_col,
    input wire logic [11:0] o_dest_row,
    input wire logic        o_dest_valid
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dest_col) && $stable(o_dest_row))
        else $error("stalled beat changed");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_dest_valid |-> (o_dest_col == 12'd0) && (o_dest_row == 12'd0))
        else $error("invalid target not zero");

    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow held output");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat after reset");

endmodule

bind radial_distortion_pixel_map_top rdpm_check u_rdpm_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_stall      (i_stall),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .o_dest_col   (o_dest_col),
    .o_dest_row   (o_dest_row),
    .o_dest_valid (o_dest_valid)
);
`default_nettype wire
